### sv/clsm_pkg.sv
// ----------------------------------------------------------------------------
// clsm_pkg
// Shared types, widths, register codes and the reciprocal table of the
// check-node label sign/magnitude mapper.
// ----------------------------------------------------------------------------
package clsm_pkg;

    localparam int INDEX_W     = 24;
    localparam int LABEL_W     = 19;
    localparam int RADIX_W     = 5;
    localparam int HALF_W      = RADIX_W - 1;
    localparam int COUNT_W     = 3;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SHIFT = 29;
    localparam int PROD_W      = INDEX_W + RECIP_W;
    localparam int RADIX_REGS  = 6;
    localparam int RADIX_IDX_W = 3;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 5;
    localparam int TDATA_IN_W  = 24;
    localparam int TDATA_OUT_W = 24;

    localparam int MAX_INPUTS_DEF = 6;
    localparam int MAX_RADIX_DEF  = 16;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd2;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd4;

    localparam logic [CFG_INDEX_W-1:0] REG_INPUT_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIX_FIRST = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIX_LAST  = 3'd6;

    // ceil(2^29 / r): exact quotient for every 24-bit dividend and r in 2..31
    localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
        29'd0,         29'd0,         29'd268435456, 29'd178956971,
        29'd134217728, 29'd107374183, 29'd89478486,  29'd76695845,
        29'd67108864,  29'd59652324,  29'd53687092,  29'd48806447,
        29'd44739243,  29'd41297763,  29'd38347923,  29'd35791395,
        29'd33554432,  29'd31580642,  29'd29826162,  29'd28256364,
        29'd26843546,  29'd25565282,  29'd24403224,  29'd23342214,
        29'd22369622,  29'd21474837,  29'd20648882,  29'd19884108,
        29'd19173962,  29'd18512791,  29'd17895698,  29'd17318417
    };

    typedef struct packed {
        logic               active;
        logic [RADIX_W-1:0] radix;
        logic [HALF_W-1:0]  half;
        logic [RECIP_W-1:0] recip;
    } clsm_digit_cfg_t;

    typedef struct packed {
        logic [INDEX_W-1:0] rest;
        logic [LABEL_W-1:0] packed_mag;
        logic [LABEL_W-1:0] base;
        logic               parity;
        logic               err;
    } clsm_item_t;

endpackage

### sv/check_label_sign_magnitude_map.sv
// ----------------------------------------------------------------------------
// check_label_sign_magnitude_map
// Splits a combined check-node index into mixed-radix digits and maps them
// to a magnitude-ordered output label.
// ----------------------------------------------------------------------------
// One index is taken every cycle unless the output is stalled by m_tready;
// each digit owns a three-stage unit (reciprocal multiply, remainder,
// magnitude packing) and a final stage forms the label. Digits beyond the
// configured input count pass through unchanged. An index at or beyond the
// radix product, or any used radix below two, gives range_error 1 and label 0.
// Radix registers must be written only while no index is in flight.
module check_label_sign_magnitude_map
    import clsm_pkg::*;
#(
    parameter int MAX_INPUTS = MAX_INPUTS_DEF,
    parameter int MAX_RADIX  = MAX_RADIX_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // [23:0] combined_index
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_OUT_W-1:0] m_tdata,   // [18:0] output_label, rest zero
    output logic                   m_tuser    // [0] range_error
);

    localparam int USED_LIMIT = (MAX_INPUTS < RADIX_REGS) ? MAX_INPUTS : RADIX_REGS;
    localparam int RADIX_CLIP = (MAX_RADIX > 31) ? 31 : MAX_RADIX;

    logic [COUNT_W-1:0] input_count_reg;
    logic [COUNT_W-1:0] input_count_next;
    logic [RADIX_W-1:0] radix_reg  [RADIX_REGS];
    logic [RADIX_W-1:0] radix_next [RADIX_REGS];
    logic [RADIX_IDX_W-1:0] radix_sel;
    logic [COUNT_W-1:0] used_count;

    clsm_digit_cfg_t dcfg [MAX_INPUTS];
    logic            bad_radix [MAX_INPUTS];
    logic            any_bad;

    logic       stg_valid [MAX_INPUTS+1];
    logic       stg_ready [MAX_INPUTS+1];
    clsm_item_t stg_item  [MAX_INPUTS+1];

    logic [LABEL_W-1:0] label;

    assign cfg_ready = 1'b1;
    assign radix_sel = cfg_index - REG_RADIX_FIRST;

    always_comb
    begin
        input_count_next = input_count_reg;
        for (int i = 0; i < RADIX_REGS; i++)
        begin
            radix_next[i] = radix_reg[i];
        end
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_INPUT_COUNT)
            begin
                input_count_next = cfg_data[COUNT_W-1:0];
            end
            else if (cfg_index >= REG_RADIX_FIRST && cfg_index <= REG_RADIX_LAST)
            begin
                radix_next[radix_sel] = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_count_reg <= COUNT_RESET;
            for (int i = 0; i < RADIX_REGS; i++)
            begin
                radix_reg[i] <= RADIX_RESET;
            end
        end
        else
        begin
            input_count_reg <= input_count_next;
            for (int i = 0; i < RADIX_REGS; i++)
            begin
                radix_reg[i] <= radix_next[i];
            end
        end
    end

    always_comb
    begin
        if (input_count_reg < 3'd1)
        begin
            used_count = 3'd1;
        end
        else if (input_count_reg > COUNT_W'(USED_LIMIT))
        begin
            used_count = COUNT_W'(USED_LIMIT);
        end
        else
        begin
            used_count = input_count_reg;
        end
    end

    for (genvar k = 0; k < MAX_INPUTS; k++)
    begin : g_cfg
        logic [RADIX_W-1:0] r_raw;
        logic [RADIX_W-1:0] r_use;
        if (k < RADIX_REGS)
        begin : g_reg
            assign r_raw = radix_reg[k];
        end
        else
        begin : g_none
            assign r_raw = '0;
        end
        assign r_use = (r_raw > RADIX_W'(RADIX_CLIP)) ? RADIX_W'(RADIX_CLIP) : r_raw;
        assign dcfg[k].active = (COUNT_W'(k) < used_count);
        assign dcfg[k].radix  = r_use;
        assign dcfg[k].half   = r_use[RADIX_W-1:1];
        assign dcfg[k].recip  = RECIP_TABLE[r_use];
        assign bad_radix[k]   = dcfg[k].active && (r_use < 5'd2);
    end

    always_comb
    begin
        any_bad = 1'b0;
        for (int k = 0; k < MAX_INPUTS; k++)
        begin
            any_bad = any_bad | bad_radix[k];
        end
    end

    assign stg_valid[0]           = s_tvalid;
    assign s_tready               = stg_ready[0];
    assign stg_item[0].rest       = s_tdata[INDEX_W-1:0];
    assign stg_item[0].packed_mag = '0;
    assign stg_item[0].base       = 19'd1;
    assign stg_item[0].parity     = 1'b0;
    assign stg_item[0].err        = any_bad;

    for (genvar k = 0; k < MAX_INPUTS; k++)
    begin : g_digit
        clsm_digit u_digit (
            .clk       (clk),
            .rst_n     (rst_n),
            .dcfg      (dcfg[k]),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    clsm_label u_label (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (stg_valid[MAX_INPUTS]),
        .in_ready    (stg_ready[MAX_INPUTS]),
        .in_item     (stg_item[MAX_INPUTS]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .label       (label),
        .range_error (m_tuser)
    );

    assign m_tdata = {{(TDATA_OUT_W-LABEL_W){1'b0}}, label};

endmodule

### sv/clsm_digit.sv
// ----------------------------------------------------------------------------
// clsm_digit
// One mixed-radix digit: reciprocal multiply, remainder, then sign/magnitude
// fold and packing, over three register stages.
// ----------------------------------------------------------------------------
module clsm_digit
    import clsm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  clsm_digit_cfg_t dcfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  clsm_item_t      in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output clsm_item_t      out_item
);

    logic              a_valid_reg;
    clsm_item_t        a_item_reg;
    logic [PROD_W-1:0] a_prod_reg;
    logic              b_valid_reg;
    clsm_item_t        b_item_reg;
    logic [RADIX_W-1:0] b_digit_reg;
    logic              c_valid_reg;
    clsm_item_t        c_item_reg;

    logic               a_ready;
    logic               b_ready;
    logic               c_ready;
    logic [PROD_W-1:0]  a_prod_next;
    logic [INDEX_W-1:0] quot;
    logic [2*RADIX_W-1:0] qr_full;
    logic [RADIX_W-1:0] b_digit_next;
    clsm_item_t         b_item_next;
    logic [RADIX_W-1:0] half_ext;
    logic [RADIX_W-1:0] mag;
    logic [LABEL_W+RADIX_W-1:0] pack_term;
    logic [LABEL_W+HALF_W-1:0]  base_prod;
    clsm_item_t         c_item_next;

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_prod_next = in_item.rest * dcfg.recip;

    always_comb
    begin
        quot         = a_prod_reg[RECIP_SHIFT +: INDEX_W];
        qr_full      = quot[RADIX_W-1:0] * dcfg.radix;
        b_digit_next = a_item_reg.rest[RADIX_W-1:0] - qr_full[RADIX_W-1:0];
        b_item_next  = a_item_reg;
        if (dcfg.active)
        begin
            b_item_next.rest = quot;
        end
    end

    always_comb
    begin
        half_ext    = {1'b0, dcfg.half};
        c_item_next = b_item_reg;
        if (b_digit_reg < half_ext)
        begin
            mag = half_ext - 5'd1 - b_digit_reg;
        end
        else
        begin
            mag = b_digit_reg - half_ext;
        end
        pack_term = b_item_reg.base * mag;
        base_prod = b_item_reg.base * dcfg.half;
        if (dcfg.active)
        begin
            c_item_next.parity     = b_item_reg.parity ^ (b_digit_reg < half_ext);
            c_item_next.packed_mag = b_item_reg.packed_mag + pack_term[LABEL_W-1:0];
            c_item_next.base       = base_prod[LABEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready)
            begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && in_valid)
        begin
            a_item_reg <= in_item;
            a_prod_reg <= a_prod_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_item_reg  <= b_item_next;
            b_digit_reg <= b_digit_next;
        end
        if (c_ready && b_valid_reg)
        begin
            c_item_reg <= c_item_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_item  = c_item_reg;

endmodule

### sv/clsm_label.sv
// ----------------------------------------------------------------------------
// clsm_label
// Output stage: range check, parity-dependent mirroring and the output
// register.
// ----------------------------------------------------------------------------
module clsm_label
    import clsm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  clsm_item_t         in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LABEL_W-1:0] label,
    output logic               range_error
);

    logic               valid_reg;
    logic [LABEL_W-1:0] label_reg;
    logic               error_reg;
    logic [LABEL_W-1:0] label_next;
    logic               error_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        error_next = in_item.err || (in_item.rest != '0);
        if (error_next)
        begin
            label_next = '0;
        end
        else if (in_item.parity)
        begin
            label_next = in_item.packed_mag;
        end
        else
        begin
            label_next = {in_item.base[LABEL_W-2:0], 1'b0} - 19'd1 - in_item.packed_mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            label_reg <= label_next;
            error_reg <= error_next;
        end
    end

    assign out_valid   = valid_reg;
    assign label       = label_reg;
    assign range_error = error_reg;

endmodule
